/* design/stream_group_reverser_unit_macros.svh */
// Assertion macros for the stream group reverser.
// Used by the top level; expects clk and rst_n in scope.
`ifndef STREAM_GROUP_REVERSER_UNIT_MACROS_SVH
`define STREAM_GROUP_REVERSER_UNIT_MACROS_SVH

// same-cycle implication
`define SGR_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sgr same-cycle check failed");

// next-cycle implication
`define SGR_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("sgr next-cycle check failed");

`endif

/* design/sgr_pkg.sv */
// Shared types and constants for the stream group reverser.
// No dependencies; imported by sgr_ctrl, sgr_dpath and the top level.
package sgr_pkg;

  localparam int MAX_GROUP = 16;
  localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int GS_W      = 5;
  localparam int K_W       = (CNT_W > GS_W) ? CNT_W : GS_W;
  localparam int VAL_W     = 32;

  localparam logic [GS_W-1:0] GS_RESET = GS_W'(1);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] item_value;
    logic                    end_of_sequence;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;
    logic more;
    logic out_free;
  } stat_t;

endpackage

/* design/sgr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module sgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/sgr_ctrl.sv */
// Sequencing FSM for the stream group reverser: fill, read, load.
// Depends on sgr_pkg for the command and status structs.
module sgr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sgr_pkg::stat_t st,
  output sgr_pkg::cmd_t  cmd
);
  import sgr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && st.emit) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        // load the pending word and, if words remain, fetch the next one in the same cycle
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.rd_issue = st.more;
          state_nxt    = st.more ? ST_LOAD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

/* design/sgr_dpath.sv */
// Datapath: group size register, fill counter, drain pointer, group RAM
// and output register. Depends on sgr_pkg and sgr_ram.
module sgr_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [sgr_pkg::GS_W-1:0] cfg_data,
  input  sgr_pkg::in_beat_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sgr_pkg::out_beat_t    out_data,
  input  sgr_pkg::cmd_t         cmd,
  output sgr_pkg::stat_t        st
);
  import sgr_pkg::*;

  logic [GS_W-1:0] gsize_r;
  cnt_t            fill_r;
  cnt_t            rem_r;
  idx_t            ptr_r;
  logic            rev_r;
  logic            eos_r;
  logic            out_valid_r;
  out_beat_t       out_data_r;

  cnt_t             n_cnt;
  logic [K_W-1:0]   k_eff;
  logic [K_W-1:0]   gs_ext;
  logic             full;
  logic [VAL_W-1:0] rd_word;

  // effective group size: zero acts as one, saturate at the buffer depth
  always_comb begin
    gs_ext = K_W'(gsize_r);
    if (gsize_r == '0) begin
      k_eff = K_W'(1);
    end else if (gs_ext > K_W'(MAX_GROUP)) begin
      k_eff = K_W'(MAX_GROUP);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign n_cnt = fill_r + cnt_t'(1);
  assign full  = (K_W'(n_cnt) >= k_eff);

  assign st.emit     = full || in_data.end_of_sequence;
  assign st.more     = (rem_r != '0);
  assign st.out_free = !out_valid_r || !out_stall;

  sgr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_GROUP)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (fill_r[IDX_W-1:0]),
    .wdata (in_data.item_value),
    .re    (cmd.rd_issue),
    .raddr (ptr_r),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r     <= GS_RESET;
      fill_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gsize_r <= cfg_data;
      end
      if (cmd.accept) begin
        if (st.emit) begin
          fill_r <= '0;
          rem_r  <= n_cnt;
        end else begin
          fill_r <= n_cnt;
        end
      end else if (cmd.rd_issue) begin
        rem_r <= rem_r - cnt_t'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && st.emit) begin
      rev_r <= full;
      eos_r <= in_data.end_of_sequence;
      ptr_r <= full ? fill_r[IDX_W-1:0] : '0;
    end else if (cmd.rd_issue) begin
      ptr_r <= rev_r ? ptr_r - idx_t'(1) : ptr_r + idx_t'(1);
    end
    if (cmd.out_load) begin
      out_data_r.out_value <= rd_word;
      // all reads issued means this is the group's final word
      out_data_r.out_last  <= eos_r && (rem_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/stream_group_reverser_unit.sv */
// Stream group reverser.
// Input beats (in_valid/in_stall/in_data) carry a signed 32-bit value and an
// end-of-sequence flag. Values collect in a 16-entry group RAM. When the
// count reaches the group size the group leaves newest first; when the
// sequence ends short of a full group the leftovers leave in arrival order.
// The final result beat of a sequence has out_last set.
// cfg_we/cfg_data write the 5-bit group size (reset 1, zero acts as 1,
// values above the buffer depth saturate); write only while idle.
// A beat that does not close a group is taken without a stall. A beat that
// closes a group of n values: the group drains through the READ and LOAD
// states over the registered RAM read port, one result per cycle while
// out_stall is low, and in_stall stays high until the last result is loaded.
// The output register lets an input beat in while a result waits.
// Out stall freezes the drain in LOAD: the held result stays and no further read is issued.
// Reset (rst_n, synchronous) empties the group and the output register and
// sets the group size to 1; RAM contents are not cleared.
// Depends on sgr_pkg, sgr_ctrl, sgr_dpath, sgr_ram and the macros header.
`include "stream_group_reverser_unit_macros.svh"

module stream_group_reverser_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [sgr_pkg::GS_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sgr_pkg::in_beat_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sgr_pkg::out_beat_t       out_data
);
  import sgr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  sgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sgr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  // a read is only issued while words remain in the group
  `SGR_ASSERT_IMP(a_read_has_word, cmd.rd_issue, st.more)
  // a closing beat blocks input for the drain
  `SGR_ASSERT_NXT(a_drain_stalls_in, cmd.accept && st.emit, in_stall)
  // a load always presents a result
  `SGR_ASSERT_NXT(a_load_shows_out, cmd.out_load, out_valid)
  // no load may overwrite a held result
  `SGR_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || !out_stall)

endmodule
